// ===== rtl/spbt_pkg.sv =====
// shared constants, types and helpers for the sparse bitmask tree encoder
// no dependencies; used by every module of the block

package spbt_pkg;

   localparam int MAX_FIELDS_DEF  = 64;
   localparam int CHUNK_WIDTH_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int FIELD_MASK_W  = 64;
   localparam int FIELD_COUNT_W = 7;
   localparam int CHUNK_BITS_W  = 32;
   localparam int CHUNK_LEN_W   = 6;

   localparam logic [FIELD_COUNT_W-1:0] FIELD_COUNT_RESET = 7'd64;

   localparam int RAW_LIMIT = 8;
   localparam int PAIR_STEP = 8;

   typedef struct packed {
      logic                     raw;
      logic [FIELD_COUNT_W-1:0] count;
   } job_ctrl_type;

   function automatic int node_width(input int max_fields);
      return 2 << $clog2(max_fields);
   endfunction

endpackage

// ===== rtl/sparse_bitmask_tree_encoder.sv =====
// top level of the sparse bitmask tree encoder: front end, job queue, code generator
// depends on spbt_pkg, spbt_front, spbt_queue, spbt_back

// Codes each field-presence mask into a packed bit stream, earliest bit in bit 0 of each
// chunk, last_chunk set on the final chunk of a mask. Up to eight fields go out raw in one
// chunk; larger counts go through an or tree that is built combinationally on intake. A
// two-entry queue sits between intake and the code generator, so new words are taken while
// earlier ones are still being coded or wait at a stalled output. The generator handles
// eight sibling pairs per cycle unless a stalled output or more than a chunk of waiting
// bits holds it; chunks leave through a single output register. field_count is for the
// user to write only while the block is idle; the block itself does not enforce this. A
// written value takes effect on the next word.

module sparse_bitmask_tree_encoder #(
   parameter int MAX_FIELDS  = spbt_pkg::MAX_FIELDS_DEF,
   parameter int CHUNK_WIDTH = spbt_pkg::CHUNK_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [spbt_pkg::FIELD_COUNT_W-1:0] csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [spbt_pkg::FIELD_MASK_W-1:0]  req_field_mask,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [spbt_pkg::CHUNK_BITS_W-1:0]  rsp_chunk_bits,
   output logic [spbt_pkg::CHUNK_LEN_W-1:0]   rsp_chunk_length,
   output logic                               rsp_last_chunk
);

   localparam int NODE_W = spbt_pkg::node_width(MAX_FIELDS);
   localparam int CTRL_W = $bits(spbt_pkg::job_ctrl_type);
   localparam int JOB_W  = CTRL_W + NODE_W;

   logic                   front_valid;
   spbt_pkg::job_ctrl_type front_ctrl;
   logic [NODE_W-1:0]      front_nodes;
   logic                   queue_full;
   logic                   queue_valid;
   logic [JOB_W-1:0]       queue_data;
   logic                   queue_pop;
   spbt_pkg::job_ctrl_type back_ctrl;
   logic [NODE_W-1:0]      back_nodes;

   spbt_front #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_field_mask   (req_field_mask),
      .req_stall        (req_stall),
      .job_valid        (front_valid),
      .job_ctrl         (front_ctrl),
      .job_nodes        (front_nodes),
      .job_full         (queue_full)
   );

   spbt_queue #(
      .DATA_W (JOB_W),
      .DEPTH  (spbt_pkg::QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  ({front_ctrl, front_nodes}),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_valid  (queue_valid),
      .pop_data   (queue_data)
   );

   assign back_ctrl  = queue_data[JOB_W-1:NODE_W];
   assign back_nodes = queue_data[NODE_W-1:0];

   spbt_back #(
      .MAX_FIELDS  (MAX_FIELDS),
      .CHUNK_WIDTH (CHUNK_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (queue_valid),
      .job_ctrl         (back_ctrl),
      .job_nodes        (back_nodes),
      .job_pop          (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_chunk_bits   (rsp_chunk_bits),
      .rsp_chunk_length (rsp_chunk_length),
      .rsp_last_chunk   (rsp_last_chunk)
   );

endmodule

// ===== rtl/spbt_front.sv =====
// front end: field count register, word intake, raw/tree classification and or-tree build
// depends on spbt_pkg

module spbt_front #(
   parameter int MAX_FIELDS = spbt_pkg::MAX_FIELDS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_write_enable,
   input  logic [spbt_pkg::FIELD_COUNT_W-1:0]          csr_write_data,
   input  logic                                        req_valid,
   input  logic [spbt_pkg::FIELD_MASK_W-1:0]           req_field_mask,
   output logic                                        req_stall,
   output logic                                        job_valid,
   output spbt_pkg::job_ctrl_type                      job_ctrl,
   output logic [spbt_pkg::node_width(MAX_FIELDS)-1:0] job_nodes,
   input  logic                                        job_full
);

   localparam int ML     = $clog2(MAX_FIELDS);
   localparam int MAXW   = 1 << ML;
   localparam int NODE_W = spbt_pkg::node_width(MAX_FIELDS);
   localparam int LVL_W  = $clog2(ML + 1);
   localparam int CNT_W  = spbt_pkg::FIELD_COUNT_W;

   logic [CNT_W-1:0]  field_count_ff;
   logic [CNT_W-1:0]  field_count_in;
   logic [CNT_W-1:0]  n_fields;
   logic [CNT_W-1:0]  n_minus;
   logic              raw_mode;
   logic [MAXW-1:0]   leaf;
   logic [NODE_W-1:0] full_tree;
   logic [NODE_W-1:0] compact;
   logic [LVL_W-1:0]  levels;
   logic [LVL_W-1:0]  dsel;
   logic [CNT_W-1:0]  pair_count;

   always_comb begin
      field_count_in = field_count_ff;
      if (csr_write_enable) begin
         field_count_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_count_ff <= spbt_pkg::FIELD_COUNT_RESET;
      end else begin
         field_count_ff <= field_count_in;
      end
   end

   // clamp to 1..MAX_FIELDS
   always_comb begin
      if (field_count_ff == '0) begin
         n_fields = CNT_W'(1);
      end else if (field_count_ff > CNT_W'(MAX_FIELDS)) begin
         n_fields = CNT_W'(MAX_FIELDS);
      end else begin
         n_fields = field_count_ff;
      end
      raw_mode = (n_fields <= CNT_W'(spbt_pkg::RAW_LIMIT));
      n_minus  = n_fields - CNT_W'(1);
   end

   // tree depth is the bit length of n - 1
   always_comb begin
      levels = '0;
      for (int b = 0; b < CNT_W; b++) begin
         if (n_minus[b]) begin
            levels = LVL_W'(b + 1);
         end
      end
      dsel       = LVL_W'(ML) - levels;
      pair_count = CNT_W'((8'd1 << levels) - 8'd1);
   end

   always_comb begin
      leaf = '0;
      for (int i = 0; i < MAX_FIELDS; i++) begin
         leaf[i] = req_field_mask[i] & (CNT_W'(i) < n_fields);
      end
   end

   // full-size or tree, leaves at MAXW..2*MAXW-1
   always_comb begin
      full_tree = '0;
      for (int i = 0; i < MAXW; i++) begin
         full_tree[MAXW + i] = leaf[i];
      end
      for (int t = MAXW - 1; t >= 1; t--) begin
         full_tree[t] = full_tree[2 * t] | full_tree[2 * t + 1];
      end
   end

   // lift the padded-width subtree (raw mode: the leaves) into heap order from node 1
   always_comb begin
      compact = '0;
      if (raw_mode) begin
         for (int i = 0; i < spbt_pkg::RAW_LIMIT; i++) begin
            compact[i + 1] = leaf[i];
         end
      end else begin
         for (int d = 0; d <= ML; d++) begin
            for (int k = 0; k <= ML - d; k++) begin
               for (int j = 0; j < (1 << k); j++) begin
                  if (dsel == LVL_W'(d)) begin
                     compact[(1 << k) + j] = full_tree[(1 << (k + d)) + j];
                  end
               end
            end
         end
      end
   end

   assign req_stall      = job_full;
   assign job_valid      = req_valid;
   assign job_ctrl.raw   = raw_mode;
   assign job_ctrl.count = raw_mode ? n_fields : pair_count;
   assign job_nodes      = compact;

endmodule

// ===== rtl/spbt_queue.sv =====
// small register queue between the front end and the code generator
// no package dependencies beyond parameter defaults from spbt_pkg

module spbt_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = spbt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/spbt_back.sv =====
// back end: walks sibling pairs eight at a time or sends raw bits, packs codes and cuts chunks
// depends on spbt_pkg

module spbt_back #(
   parameter int MAX_FIELDS  = spbt_pkg::MAX_FIELDS_DEF,
   parameter int CHUNK_WIDTH = spbt_pkg::CHUNK_WIDTH_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        job_valid,
   input  spbt_pkg::job_ctrl_type                      job_ctrl,
   input  logic [spbt_pkg::node_width(MAX_FIELDS)-1:0] job_nodes,
   output logic                                        job_pop,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [spbt_pkg::CHUNK_BITS_W-1:0]           rsp_chunk_bits,
   output logic [spbt_pkg::CHUNK_LEN_W-1:0]            rsp_chunk_length,
   output logic                                        rsp_last_chunk
);

   localparam int NODE_W    = spbt_pkg::node_width(MAX_FIELDS);
   localparam int STEP      = spbt_pkg::PAIR_STEP;
   localparam int GEN_W     = 2 * STEP + 1;
   localparam int GEN_LEN_W = $clog2(GEN_W + 1);
   localparam int ACC_W     = CHUNK_WIDTH + GEN_W;
   localparam int ACC_LEN_W = $clog2(ACC_W + 1);
   localparam int CNT_W     = spbt_pkg::FIELD_COUNT_W;
   localparam int OUT_W     = spbt_pkg::CHUNK_BITS_W;
   localparam int LEN_W     = spbt_pkg::CHUNK_LEN_W;

   logic                 gen_active_ff;
   logic                 gen_active_in;
   logic                 raw_ff;
   logic                 raw_in;
   logic                 first_ff;
   logic                 first_in;
   logic [CNT_W-1:0]     rem_ff;
   logic [CNT_W-1:0]     rem_in;
   logic [NODE_W-2:0]    parent_ff;
   logic [NODE_W-2:0]    parent_in;
   logic [NODE_W-3:0]    child_ff;
   logic [NODE_W-3:0]    child_in;
   logic [ACC_W-1:0]     acc_ff;
   logic [ACC_W-1:0]     acc_in;
   logic [ACC_LEN_W-1:0] acc_len_ff;
   logic [ACC_LEN_W-1:0] acc_len_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [OUT_W-1:0]     rsp_bits_ff;
   logic [OUT_W-1:0]     rsp_bits_in;
   logic [LEN_W-1:0]     rsp_len_ff;
   logic [LEN_W-1:0]     rsp_len_in;
   logic                 rsp_last_ff;
   logic                 rsp_last_in;

   logic [GEN_W-1:0]     gbits;
   logic [GEN_LEN_W-1:0] glen;
   logic                 out_free;
   logic                 emit;
   logic                 emit_last;
   logic [ACC_LEN_W-1:0] take;
   logic [ACC_W-1:0]     acc_after;
   logic [ACC_LEN_W-1:0] len_after;
   logic                 gen_go;
   logic                 step_final;
   logic                 load;
   logic [OUT_W-1:0]     chunk_word;

   // codes for up to eight sibling pairs, root bit in front on the first step; up to eight raw bits in raw mode
   always_comb begin
      gbits = '0;
      glen  = '0;
      if (raw_ff) begin
         for (int s = 0; s < spbt_pkg::RAW_LIMIT; s++) begin
            if (CNT_W'(s) < rem_ff) begin
               gbits[s] = parent_ff[s];
            end
         end
         glen = GEN_LEN_W'(rem_ff);
      end else begin
         if (first_ff) begin
            gbits[0] = parent_ff[0];
            glen     = GEN_LEN_W'(1);
         end
         for (int s = 0; s < STEP; s++) begin
            if ((CNT_W'(s) < rem_ff) && parent_ff[s]) begin
               if (child_ff[2 * s] && !child_ff[2 * s + 1]) begin
                  glen = glen + GEN_LEN_W'(1);
               end else begin
                  gbits[glen]                  = 1'b1;
                  gbits[glen + GEN_LEN_W'(1)] = child_ff[2 * s];
                  glen                         = glen + GEN_LEN_W'(2);
               end
            end
         end
      end
   end

   generate
      for (genvar b = 0; b < OUT_W; b++) begin : g_word
         if (b < CHUNK_WIDTH) begin : g_bit
            assign chunk_word[b] = acc_ff[b];
         end else begin : g_pad
            assign chunk_word[b] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      emit_last  = !gen_active_ff && (acc_len_ff <= ACC_LEN_W'(CHUNK_WIDTH));
      if (gen_active_ff) begin
         emit = out_free && (acc_len_ff > ACC_LEN_W'(CHUNK_WIDTH));
      end else begin
         emit = out_free && (acc_len_ff != '0);
      end
      take = emit_last ? acc_len_ff : ACC_LEN_W'(CHUNK_WIDTH);

      acc_after = acc_ff;
      len_after = acc_len_ff;
      if (emit) begin
         if (emit_last) begin
            acc_after = '0;
            len_after = '0;
         end else begin
            acc_after = acc_ff >> CHUNK_WIDTH;
            len_after = acc_len_ff - ACC_LEN_W'(CHUNK_WIDTH);
         end
      end

      gen_go     = gen_active_ff && (len_after <= ACC_LEN_W'(CHUNK_WIDTH));
      step_final = raw_ff || (rem_ff <= CNT_W'(STEP));
      load       = job_valid && !gen_active_ff && (len_after == '0);

      acc_in     = acc_after;
      acc_len_in = len_after;
      if (gen_go) begin
         acc_in     = acc_after | (ACC_W'(gbits) << len_after);
         acc_len_in = len_after + ACC_LEN_W'(glen);
      end

      gen_active_in = gen_active_ff;
      raw_in        = raw_ff;
      first_in      = first_ff;
      rem_in        = rem_ff;
      parent_in     = parent_ff;
      child_in      = child_ff;
      if (load) begin
         gen_active_in = 1'b1;
         raw_in        = job_ctrl.raw;
         first_in      = 1'b1;
         rem_in        = job_ctrl.count;
         parent_in     = job_nodes[NODE_W-1:1];
         child_in      = job_nodes[NODE_W-1:2];
      end else if (gen_go) begin
         gen_active_in = !step_final;
         first_in      = 1'b0;
         rem_in        = (rem_ff > CNT_W'(STEP)) ? rem_ff - CNT_W'(STEP) : '0;
         parent_in     = parent_ff >> STEP;
         child_in      = child_ff >> (2 * STEP);
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_bits_in  = chunk_word;
         rsp_len_in   = LEN_W'(take);
         rsp_last_in  = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_active_ff <= 1'b0;
         acc_ff        <= '0;
         acc_len_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gen_active_ff <= gen_active_in;
         acc_ff        <= acc_in;
         acc_len_ff    <= acc_len_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      first_ff    <= first_in;
      rem_ff      <= rem_in;
      parent_ff   <= parent_in;
      child_ff    <= child_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign job_pop          = load;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chunk_bits   = rsp_bits_ff;
   assign rsp_chunk_length = rsp_len_ff;
   assign rsp_last_chunk   = rsp_last_ff;

endmodule
